[design/ack_driven_window_controller_core_defines.svh]
// Assertion macros shared by the window controller modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef ACK_DRIVEN_WINDOW_CONTROLLER_CORE_DEFINES_SVH
`define ACK_DRIVEN_WINDOW_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ADWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ADWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/adwc_pkg.sv]
// Shared types and constants for the ack-driven window controller.
// Depends on nothing; imported by every module of the block.
package adwc_pkg;

    localparam int DEF_FRACTION_BITS = 16;
    localparam int DEF_WHOLE_BITS    = 16;
    localparam int WIN_RESET_WHOLE   = 15;
    localparam logic [15:0] TIMEOUT_RESET = 16'd80;

    typedef struct packed {
        logic [31:0] sent_time_ms;
        logic [31:0] ack_time_ms;
    } in_t;

    typedef struct packed {
        logic [15:0] window_whole;
        logic [31:0] window_fixed;
        logic        slow_start_active;
        logic        late_ack;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic update;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic late;
        logic fast;
        logic div_last;
    } sts_t;

endpackage

[design/adwc_ctrl.sv]
// Sequencing state machine of the window controller and the result valid flag.
// Depends on adwc_pkg and the assertion macro header.
`include "ack_driven_window_controller_core_defines.svh"

module adwc_ctrl
    import adwc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_APPLY
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   apply_go;

    // The result register may be refilled in the same cycle its request leaves.
    assign apply_go = (state_reg == ST_APPLY) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.late || sts.fast) begin
                    state_next = ST_APPLY;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (apply_go) begin
                    cmd.update   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `ADWC_ASSERT_NEXT(a_accept_to_decide, aclk, aresetn,
        s_valid && s_ready, state_reg == ST_DECIDE,
        "accepted request did not move to decision")
    `ADWC_ASSERT_NOW(a_div_only_additive, aclk, aresetn,
        state_reg == ST_DIV, !sts.late && !sts.fast,
        "divider running for a late or slow-start ack")
    `ADWC_ASSERT_NEXT(a_apply_holds, aclk, aresetn,
        state_reg == ST_APPLY && m_valid_reg && !m_ready,
        state_reg == ST_APPLY && m_valid_reg,
        "pending result overwritten")

endmodule

[design/adwc_dpath.sv]
// Window datapath: timeout register, RTT check, restoring divider for 2/window,
// saturating update with floor, and the result register. Depends on adwc_pkg.
`include "ack_driven_window_controller_core_defines.svh"

module adwc_dpath
    import adwc_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int WHOLE_BITS    = DEF_WHOLE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  in_t         s_data,
    output out_t        m_data,
    input  cmd_t        cmd,
    output sts_t        sts
);

    localparam int W  = WHOLE_BITS + FRACTION_BITS;
    localparam int N  = 2 * FRACTION_BITS + 2;
    localparam int SW = ((W > N) ? W : N) + 1;
    localparam int CW = $clog2(N);
    localparam logic [W-1:0]  WIN_ONE   = {{(W-1){1'b0}}, 1'b1} << FRACTION_BITS;
    localparam logic [W-1:0]  WIN_MAX   = {W{1'b1}};
    localparam logic [W-1:0]  WIN_RESET = W'(WIN_RESET_WHOLE) << FRACTION_BITS;
    localparam logic [SW-1:0] FAST_INC  = SW'(2) << FRACTION_BITS;
    localparam logic [CW-1:0] CNT_TOP   = CW'(N - 1);

    in_t          in_reg;
    logic [15:0]  timeout_reg, timeout_next;
    logic [W-1:0] win_reg, win_next;
    logic         fast_reg, fast_next;
    logic [W:0]   rem_reg, rem_next;
    logic [N-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    out_t         out_reg;

    logic [31:0]   rtt;
    logic          late;
    logic [W-1:0]  den;
    logic [W:0]    trial;
    logic          trial_ge;
    logic [SW-1:0] add_b;
    logic [SW-1:0] sum;
    logic [W-1:0]  grown;
    logic [W-1:0]  floored;
    logic [W+31:0] win_wide;
    logic [W+31:0] whole_wide;

    assign rtt  = in_reg.ack_time_ms - in_reg.sent_time_ms;
    assign late = rtt > {16'b0, timeout_reg};

    // The dividend is a single one at bit N-1, so its bits come from the step count.
    assign den      = (win_reg == '0) ? {{(W-1){1'b0}}, 1'b1} : win_reg;
    assign trial    = {rem_reg[W-1:0], (cnt_reg == CNT_TOP)};
    assign trial_ge = trial >= {1'b0, den};

    assign add_b   = fast_reg ? FAST_INC : SW'(quo_reg);
    assign sum     = SW'(win_reg) + add_b;
    assign grown   = late ? (win_reg >> 1)
                   : ((sum > SW'(WIN_MAX)) ? WIN_MAX : sum[W-1:0]);
    assign floored = (grown < WIN_ONE) ? WIN_ONE : grown;

    assign win_wide   = (W + 32)'(floored);
    assign whole_wide = win_wide >> FRACTION_BITS;

    always_comb begin
        timeout_next = cfg_we ? cfg_wdata : timeout_reg;
        win_next     = win_reg;
        fast_next    = fast_reg;
        if (cmd.update) begin
            win_next  = floored;
            fast_next = fast_reg && !late;
        end
    end

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.div_start) begin
            rem_next = '0;
            quo_next = '0;
            cnt_next = CNT_TOP;
        end else if (cmd.div_step) begin
            rem_next = trial_ge ? (trial - {1'b0, den}) : trial;
            quo_next = {quo_reg[N-2:0], trial_ge};
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            win_reg     <= WIN_RESET;
            fast_reg    <= 1'b1;
        end else begin
            timeout_reg <= timeout_next;
            win_reg     <= win_next;
            fast_reg    <= fast_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.update) begin
            out_reg.window_whole      <= whole_wide[15:0];
            out_reg.window_fixed      <= win_wide[31:0];
            out_reg.slow_start_active <= fast_reg && !late;
            out_reg.late_ack          <= late;
        end
    end

    assign m_data       = out_reg;
    assign sts.late     = late;
    assign sts.fast     = fast_reg;
    assign sts.div_last = (cnt_reg == '0);

    `ADWC_ASSERT_NOW(a_win_floor, aclk, aresetn,
        1'b1, win_reg >= WIN_ONE,
        "window below one")
    `ADWC_ASSERT_NEXT(a_fast_stays_off, aclk, aresetn,
        !fast_reg, !fast_reg,
        "slow start resumed")
    `ADWC_ASSERT_NEXT(a_late_ends_fast, aclk, aresetn,
        cmd.update && late, !fast_reg && out_reg.late_ack,
        "late ack did not end slow start")

endmodule

[design/ack_driven_window_controller_core.sv]
// Top level of the ack-driven window controller (AIMD with slow start).
// Depends on adwc_pkg, adwc_ctrl and adwc_dpath.
//
// Usage: each request on the s_ channel is one acknowledgement with its send and
// arrival times in ms. The round-trip time is their difference modulo 2^32. A
// time above the timeout register halves the window and ends slow start for
// good; otherwise the window grows by 2.0 in slow start or by 2.0/window after.
// The window is floored at 1.0 and saturates at its format maximum. Every ack
// gives one result request on the m_ channel with the updated window.
// cfg_we/cfg_wdata write the timeout register; the user must do so only while
// idle, as the block does not enforce it. An accepted ack goes from DECIDE to
// APPLY if late or in slow start, else through DIV, the restoring divider that
// forms 2.0/window one quotient bit per cycle. APPLY loads the result register
// and sets m_valid. One ack is in work at a time; the next is taken once the
// last has left APPLY. A result waiting in the output register does not block
// acceptance; if the receiver stalls, the next result waits in its final step.
// Reset: window 15.0, slow start on, timeout 80 ms, no result pending.
module ack_driven_window_controller_core
    import adwc_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int WHOLE_BITS    = DEF_WHOLE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data
);

    cmd_t cmd;
    sts_t sts;

    adwc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    adwc_dpath #(
        .FRACTION_BITS (FRACTION_BITS),
        .WHOLE_BITS    (WHOLE_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[test/tb_ack_driven_window_controller_core.sv]
`timescale 1ns / 100ps
// Testbench for ack_driven_window_controller_core: drives acks and checks every window result.
// Depends on adwc_pkg and the design files of the window controller.
module tb_ack_driven_window_controller_core;
    import adwc_pkg::*;

    localparam int FRAC        = DEF_FRACTION_BITS;
    localparam int WHOLE       = DEF_WHOLE_BITS;
    localparam int TAIL_CYCLES = 2 * FRAC + 8;
    localparam int STALL_LIMIT = 2000;
    localparam int CLIMB_ACKS  = 150;
    localparam int PHASE_ACKS  = 210;
    localparam logic [63:0] WIN_ONE = 64'd1 << FRAC;
    localparam logic [63:0] WIN_MAX = (64'd1 << (FRAC + WHOLE)) - 64'd1;

    // Tracks the congestion window and holds the results still owed by the block.
    class window_tracker;
        logic [63:0] win;
        logic        fast;
        logic [15:0] limit_ms;
        out_t        window_due[$];
        int          errors;

        function new();
            win      = 64'(WIN_RESET_WHOLE) << FRAC;
            fast     = 1'b1;
            limit_ms = TIMEOUT_RESET;
            errors   = 0;
        endfunction

        function void note_request(in_t req);
            logic [31:0] rtt;
            logic [63:0] gain;
            logic [63:0] grown;
            out_t        res;
            rtt = req.ack_time_ms - req.sent_time_ms;
            res.late_ack = (rtt > {16'd0, limit_ms});
            if (res.late_ack) begin
                fast = 1'b0;
                win  = win >> 1;
            end else begin
                if (fast) begin
                    gain = 64'd2 << FRAC;
                end else begin
                    gain = (64'd2 << (2 * FRAC)) / ((win == 64'd0) ? 64'd1 : win);
                end
                grown = win + gain;
                win   = (grown > WIN_MAX) ? WIN_MAX : grown;
            end
            if (win < WIN_ONE)
                win = WIN_ONE;
            res.window_whole      = 16'(win >> FRAC);
            res.window_fixed      = win[31:0];
            res.slow_start_active = fast;
            window_due.push_back(res);
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= 10)
                $display("%t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (window_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%t: result with no request outstanding, window %0d",
                             $time, got.window_fixed);
            end else begin
                want = window_due.pop_front();
                if (got.window_whole !== want.window_whole)
                    flag("window_whole", want.window_whole, got.window_whole);
                if (got.window_fixed !== want.window_fixed)
                    flag("window_fixed", want.window_fixed, got.window_fixed);
                if (got.slow_start_active !== want.slow_start_active)
                    flag("slow_start_active", want.slow_start_active, got.slow_start_active);
                if (got.late_ack !== want.late_ack)
                    flag("late_ack", want.late_ack, got.late_ack);
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    in_t         s_data    = '0;
    logic        m_ready   = 1'b0;
    logic        s_ready;
    logic        m_valid;
    out_t        m_data;

    bit            idle_on      = 1'b1;
    int            quiet_cycles = 0;
    window_tracker board;

    ack_driven_window_controller_core #(
        .FRACTION_BITS(FRAC),
        .WHOLE_BITS   (WHOLE)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= 27);
    end

    // Results are checked before the request of the same edge is noted; a result
    // can never belong to a request accepted at that very edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_result(m_data);
            if (s_valid && s_ready)
                board.note_request(s_data);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_ack_driven_window_controller_core: done, errors");
            $finish;
        end
    end

    // Valid stays high from one request to the next unless a gap is drawn.
    task automatic send_ack(input logic [31:0] sent, input logic [31:0] acked);
        if (idle_on) begin
            while ($urandom_range(99) < 27) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= '{sent_time_ms: sent, ack_time_ms: acked};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.window_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        hold_until_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.limit_ms = value;
    endtask

    task automatic send_random(input int late_pct);
        logic [31:0] sent;
        logic [31:0] rtt;
        logic [31:0] tmo;
        sent = $urandom;
        tmo  = {16'd0, board.limit_ms};
        if ($urandom_range(99) < late_pct) begin
            case ($urandom_range(2))
                0: rtt = tmo + 32'd1 + $urandom_range(3);
                1: rtt = $urandom_range(32'hFFFF_FFFF, tmo + 32'd1);
                default: rtt = 32'hFFFF_FFFF - $urandom_range(1000);
            endcase
        end else if ($urandom_range(3) == 0) begin
            rtt = tmo;
        end else begin
            rtt = $urandom_range(tmo, 0);
        end
        send_ack(sent, sent + rtt);
    endtask

    initial begin
        logic [31:0] t0;
        int          late_pcts[5];
        logic [15:0] phase_tmo[5];
        board     = new();
        late_pcts = '{15, 30, 20, 3, 10};
        phase_tmo = '{16'd80, 16'($urandom_range(300, 1)), 16'd0, 16'hFFFF, 16'($urandom)};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Slow start at the reset timeout; an RTT equal to the timeout is on time,
        // including one that wraps around the clock.
        send_ack(32'd0, 32'd0);
        send_ack(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_ack(32'hFFFF_FFFF, 32'd79);
        send_ack(32'd0, 32'd80);

        // Long run without gaps that keeps growing the window in slow start.
        idle_on = 1'b0;
        repeat (CLIMB_ACKS) send_random(0);
        idle_on = 1'b1;

        // A wrapped ack is late and ends slow start; then divide with a large window.
        send_ack(32'd1, 32'd0);
        send_ack(32'd0, 32'd80);
        send_ack(32'hFFFF_FFF0, 32'h0000_0040);
        send_ack(32'h1234_5678, 32'h1234_5678);

        // Halve down to the floor and keep hitting it.
        repeat (9) begin
            t0 = $urandom;
            send_ack(t0, t0 - 32'd1);
            send_ack(t0, t0 + 32'd81);
        end

        write_timeout(16'd0);
        t0 = $urandom;
        send_ack(t0, t0);
        send_ack(t0, t0 + 32'd1);

        write_timeout(16'hFFFF);
        send_ack(32'd0, 32'h0000_FFFF);
        send_ack(32'hFFFF_0000, 32'hFFFF_FFFF);
        send_ack(32'd0, 32'h0001_0000);

        for (int p = 0; p < 5; p++) begin
            write_timeout(phase_tmo[p]);
            for (int i = 0; i < PHASE_ACKS; i++) begin
                if (p == 2 && i == PHASE_ACKS / 2)
                    hold_until_drained();
                send_random(late_pcts[p]);
            end
        end

        hold_until_drained();
        if (board.errors == 0 && board.window_due.size() == 0)
            $display("tb_ack_driven_window_controller_core: done, clean");
        else
            $display("tb_ack_driven_window_controller_core: done, errors");
        $finish;
    end

endmodule
